// File: hdl/quadrature_detent_pitch_adjuster_macros.svh
// Assertion macros shared by the pitch adjuster RTL.
`ifndef QUADRATURE_DETENT_PITCH_ADJUSTER_MACROS_SVH
`define QUADRATURE_DETENT_PITCH_ADJUSTER_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define QDPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset.
`define QDPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/qdpa_pkg.sv
// Package with the types and constants of the quadrature detent pitch adjuster.
package qdpa_pkg;

  localparam int PITCH_BITS_DEFAULT = 10;
  localparam int OUT_PITCH_W        = 10;
  localparam int HOME_W             = 10;
  localparam int WORD_W             = 3;
  localparam int CNT_W              = 4;

  localparam logic [HOME_W-1:0] HOME_RESET = 10'd440;
  localparam logic [WORD_W-1:0] PUSH_WORD  = 3'd7;

  typedef enum logic [1:0] {
    PH_B    = 2'b00,
    PH_A    = 2'b01,
    PH_C    = 2'b10,
    PH_REST = 2'b11
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_PUSH = 2'd1,
    EV_UP   = 2'd2,
    EV_DOWN = 2'd3
  } event_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] count;
  } track_t;

  typedef struct packed {
    logic [OUT_PITCH_W-1:0] pitch;
    event_t                 event_code;
  } result_t;

endpackage

// File: hdl/qdpa_step.sv
// Combinational detent tracker: next phase, count, pitch and event for one sample.
module qdpa_step #(
  parameter int PITCH_BITS = qdpa_pkg::PITCH_BITS_DEFAULT
) (
  input  logic [qdpa_pkg::WORD_W-1:0] word,
  input  logic [qdpa_pkg::HOME_W-1:0] home_pitch,
  input  qdpa_pkg::track_t            track_cur,
  input  logic [PITCH_BITS-1:0]       pitch_cur,
  output qdpa_pkg::track_t            track_nxt,
  output logic [PITCH_BITS-1:0]       pitch_nxt,
  output qdpa_pkg::event_t            event_nxt
);

  localparam logic [PITCH_BITS-1:0] PITCH_MAX = {PITCH_BITS{1'b1}};

  logic [PITCH_BITS-1:0] home_clamped;

  generate
    if (PITCH_BITS >= qdpa_pkg::HOME_W) begin : g_home_wide
      assign home_clamped = PITCH_BITS'(home_pitch);
    end else begin : g_home_narrow
      assign home_clamped = (home_pitch > qdpa_pkg::HOME_W'(PITCH_MAX)) ?
                            PITCH_MAX : home_pitch[PITCH_BITS-1:0];
    end
  endgenerate

  always_comb begin
    qdpa_pkg::track_t      t;
    logic [PITCH_BITS-1:0] p;
    qdpa_pkg::event_t      ev;
    t  = track_cur;
    p  = pitch_cur;
    ev = qdpa_pkg::EV_NONE;
    if (word == qdpa_pkg::PUSH_WORD) begin
      t.phase = qdpa_pkg::PH_REST;
      t.count = 4'd4;
      p       = home_clamped;
      ev      = qdpa_pkg::EV_PUSH;
    end
    unique case (t.phase)
      qdpa_pkg::PH_REST: begin
        if (t.count == 4'd8 || t.count == 4'd0) begin
          t.count = 4'd4;
        end
        if (word == {1'b0, qdpa_pkg::PH_A} && t.count == 4'd4) begin
          t.count = 4'd5;
          t.phase = qdpa_pkg::PH_A;
        end else if (word == {1'b0, qdpa_pkg::PH_C} && t.count == 4'd4) begin
          t.count = 4'd3;
          t.phase = qdpa_pkg::PH_C;
        end
      end
      qdpa_pkg::PH_A: begin
        if (word == {1'b0, qdpa_pkg::PH_REST} && t.count == 4'd1) begin
          t.count = 4'd0;
          t.phase = qdpa_pkg::PH_REST;
          if (p != '0) begin
            p = p - 1'b1;
          end
          ev = qdpa_pkg::EV_DOWN;
        end else if (word == {1'b0, qdpa_pkg::PH_B} && t.count == 4'd5) begin
          t.count = 4'd6;
          t.phase = qdpa_pkg::PH_B;
        end
      end
      qdpa_pkg::PH_B: begin
        if (word == {1'b0, qdpa_pkg::PH_A} && t.count == 4'd2) begin
          t.count = 4'd1;
          t.phase = qdpa_pkg::PH_A;
        end else if (word == {1'b0, qdpa_pkg::PH_C} && t.count == 4'd6) begin
          t.count = 4'd7;
          t.phase = qdpa_pkg::PH_C;
        end
      end
      qdpa_pkg::PH_C: begin
        if (word == {1'b0, qdpa_pkg::PH_B} && t.count == 4'd3) begin
          t.count = 4'd2;
          t.phase = qdpa_pkg::PH_B;
        end else if (word == {1'b0, qdpa_pkg::PH_REST} && t.count == 4'd7) begin
          t.count = 4'd8;
          t.phase = qdpa_pkg::PH_REST;
          if (p != PITCH_MAX) begin
            p = p + 1'b1;
          end
          ev = qdpa_pkg::EV_UP;
        end
      end
      default: begin
        t = track_cur;
      end
    endcase
    track_nxt = t;
    pitch_nxt = p;
    event_nxt = ev;
  end

endmodule

// File: hdl/qdpa_out_fifo.sv
// Two-entry result queue between the tracker and the output channel.
module qdpa_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  qdpa_pkg::result_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output qdpa_pkg::result_t rd_data
);

  qdpa_pkg::result_t mem_r [2];
  logic              wr_ptr_r;
  logic              wr_ptr_nxt;
  logic              rd_ptr_r;
  logic              rd_ptr_nxt;
  logic [1:0]        fill_r;
  logic [1:0]        fill_nxt;
  logic              wr_fire;
  logic              rd_fire;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_fire ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_fire ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, wr_fire} - {1'b0, rd_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hdl/quadrature_detent_pitch_adjuster.sv
// Top level of the quadrature detent pitch adjuster.
// A result enters the result queue at its input transfer, and out_valid is high in the cycle after.
// Throughput: one sample per cycle; a two-entry result queue keeps input open while
// one result waits, and input stalls only when both entries are held.
// Reset (synchronous, rst_n low): phase 11, detent count 4, pitch and home pitch 440
// (pitch clamped to its maximum), result queue empty.
module quadrature_detent_pitch_adjuster #(
  parameter int PITCH_BITS = qdpa_pkg::PITCH_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qdpa_pkg::HOME_W-1:0]      cfg_home_pitch,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [qdpa_pkg::WORD_W-1:0]      in_encoder_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [qdpa_pkg::OUT_PITCH_W-1:0] out_pitch,
  output logic [1:0]                       out_event_code
);

`include "quadrature_detent_pitch_adjuster_macros.svh"

  localparam int PITCH_MAX_I   = (1 << PITCH_BITS) - 1;
  localparam int HOME_RESET_I  = int'(qdpa_pkg::HOME_RESET);
  localparam int PITCH_RESET_I = (HOME_RESET_I > PITCH_MAX_I) ? PITCH_MAX_I : HOME_RESET_I;
  localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(PITCH_RESET_I);

  logic [qdpa_pkg::HOME_W-1:0]      home_r;
  qdpa_pkg::track_t                 track_r;
  qdpa_pkg::track_t                 track_nxt;
  logic [PITCH_BITS-1:0]            pitch_r;
  logic [PITCH_BITS-1:0]            pitch_nxt;
  qdpa_pkg::event_t                 event_nxt;
  qdpa_pkg::result_t                res_in;
  qdpa_pkg::result_t                res_out;
  logic [qdpa_pkg::OUT_PITCH_W-1:0] pitch_out;
  logic                             in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  qdpa_step #(
    .PITCH_BITS (PITCH_BITS)
  ) u_step (
    .word       (in_encoder_word),
    .home_pitch (home_r),
    .track_cur  (track_r),
    .pitch_cur  (pitch_r),
    .track_nxt  (track_nxt),
    .pitch_nxt  (pitch_nxt),
    .event_nxt  (event_nxt)
  );

  generate
    if (PITCH_BITS >= qdpa_pkg::OUT_PITCH_W) begin : g_out_wide
      assign pitch_out = pitch_nxt[qdpa_pkg::OUT_PITCH_W-1:0];
    end else begin : g_out_narrow
      assign pitch_out = {{(qdpa_pkg::OUT_PITCH_W-PITCH_BITS){1'b0}}, pitch_nxt};
    end
  endgenerate

  assign res_in.pitch      = pitch_out;
  assign res_in.event_code = event_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r        <= qdpa_pkg::HOME_RESET;
      track_r.phase <= qdpa_pkg::PH_REST;
      track_r.count <= 4'd4;
      pitch_r       <= PITCH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        home_r <= cfg_home_pitch;
      end
      if (in_fire) begin
        track_r <= track_nxt;
        pitch_r <= pitch_nxt;
      end
    end
  end

  qdpa_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (res_in),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (res_out)
  );

  assign out_pitch      = res_out.pitch;
  assign out_event_code = res_out.event_code;

  `QDPA_ASSERT_NEXT(a_push_rests, in_fire && in_encoder_word == qdpa_pkg::PUSH_WORD, track_r.phase == qdpa_pkg::PH_REST && track_r.count == 4'd4, "push did not return tracker to rest")
  `QDPA_ASSERT_NOW(a_count_range, 1'b1, track_r.count <= 4'd8, "detent count out of range")
  `QDPA_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid, "input stalled with no result pending")
  `QDPA_ASSERT_NEXT(a_transfer_offers, in_fire, out_valid, "accepted sample produced no result")

endmodule

// File: bench/tb_quadrature_detent_pitch_adjuster.sv
// Self-checking testbench for the quadrature detent pitch adjuster.
module tb_quadrature_detent_pitch_adjuster;
  timeunit 1ns;
  timeprecision 1ps;

  import qdpa_pkg::*;

  localparam int PITCH_MAX     = (1 << PITCH_BITS_DEFAULT) - 1;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 50;

  typedef logic [WORD_W-1:0] word_t;

  class knob_scoreboard;
    phase_t                 knob_phase;
    logic [CNT_W-1:0]       detent_count;
    logic [OUT_PITCH_W-1:0] pitch_now;
    logic [HOME_W-1:0]      home_pitch;
    result_t                results_due[$];
    int                     errors;

    function new();
      knob_phase   = PH_REST;
      detent_count = 4'd4;
      home_pitch   = HOME_RESET;
      pitch_now    = clamp_pitch(HOME_RESET);
      errors       = 0;
    endfunction

    function logic [OUT_PITCH_W-1:0] clamp_pitch(logic [HOME_W-1:0] value);
      return (value > PITCH_MAX) ? OUT_PITCH_W'(PITCH_MAX) : OUT_PITCH_W'(value);
    endfunction

    function void set_home(logic [HOME_W-1:0] value);
      home_pitch = value;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void note_sample(word_t word);
      event_t  code;
      result_t due;
      code = EV_NONE;
      if (word == PUSH_WORD) begin
        knob_phase   = PH_REST;
        detent_count = 4'd4;
        pitch_now    = clamp_pitch(home_pitch);
        code         = EV_PUSH;
      end
      case (knob_phase)
        PH_REST: begin
          if (detent_count == 4'd8 || detent_count == 4'd0) detent_count = 4'd4;
          if (word == {1'b0, PH_A} && detent_count == 4'd4) begin
            detent_count = 4'd5;
            knob_phase   = PH_A;
          end else if (word == {1'b0, PH_C} && detent_count == 4'd4) begin
            detent_count = 4'd3;
            knob_phase   = PH_C;
          end
        end
        PH_A: begin
          if (word == {1'b0, PH_REST} && detent_count == 4'd1) begin
            detent_count = 4'd0;
            knob_phase   = PH_REST;
            if (pitch_now != 0) pitch_now = pitch_now - 1'b1;
            code = EV_DOWN;
          end else if (word == {1'b0, PH_B} && detent_count == 4'd5) begin
            detent_count = 4'd6;
            knob_phase   = PH_B;
          end
        end
        PH_B: begin
          if (word == {1'b0, PH_A} && detent_count == 4'd2) begin
            detent_count = 4'd1;
            knob_phase   = PH_A;
          end else if (word == {1'b0, PH_C} && detent_count == 4'd6) begin
            detent_count = 4'd7;
            knob_phase   = PH_C;
          end
        end
        default: begin
          if (word == {1'b0, PH_B} && detent_count == 4'd3) begin
            detent_count = 4'd2;
            knob_phase   = PH_B;
          end else if (word == {1'b0, PH_REST} && detent_count == 4'd7) begin
            detent_count = 4'd8;
            knob_phase   = PH_REST;
            if (pitch_now < PITCH_MAX) pitch_now = pitch_now + 1'b1;
            code = EV_UP;
          end
        end
      endcase
      due.pitch      = pitch_now;
      due.event_code = code;
      results_due.push_back(due);
    endfunction

    function void check_result(logic [OUT_PITCH_W-1:0] pitch_seen, logic [1:0] code_seen);
      result_t due;
      if (results_due.size() == 0) begin
        $display("%0t: result with none pending: pitch %0d event %0d",
                 $time, pitch_seen, code_seen);
        errors++;
        return;
      end
      due = results_due.pop_front();
      if (pitch_seen !== due.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, due.pitch, pitch_seen);
        errors++;
      end
      if (code_seen !== 2'(due.event_code)) begin
        $display("%0t: event expected %0d actual %0d", $time, due.event_code, code_seen);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [HOME_W-1:0]      cfg_home_pitch;
  logic                   in_valid;
  logic                   in_ready;
  word_t                  in_encoder_word;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_PITCH_W-1:0] out_pitch;
  logic [1:0]             out_event_code;

  knob_scoreboard board = new();
  word_t          knob_words[$];
  bit             in_steady;
  int unsigned    cycle_count = 0;

  quadrature_detent_pitch_adjuster u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_home_pitch (cfg_home_pitch),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_encoder_word(in_encoder_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pitch      (out_pitch),
    .out_event_code (out_event_code)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_detent(input bit clockwise, input int steps);
    phase_t cw_path [4]  = '{PH_A, PH_B, PH_C, PH_REST};
    phase_t ccw_path [4] = '{PH_C, PH_B, PH_A, PH_REST};
    for (int i = 0; i < steps; i++)
      knob_words.push_back(clockwise ? {1'b0, cw_path[i]} : {1'b0, ccw_path[i]});
  endtask

  task automatic play_knob_words();
    int gap;
    foreach (knob_words[i]) begin
      gap = in_steady ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid        <= 1'b1;
      in_encoder_word <= knob_words[i];
      do @(posedge clk); while (!in_ready);
      board.note_sample(knob_words[i]);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    knob_words.delete();
  endtask

  task automatic write_home(input logic [HOME_W-1:0] value);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_home_pitch <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_home(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_pitch, out_event_code);
    end
  end

  initial begin : knob_stimulus
    logic [HOME_W-1:0] phase_homes [RANDOM_PHASES];
    int                pick;
    int                cw_bias;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_home_pitch  = '0;
    in_valid        = 1'b0;
    in_encoder_word = '0;
    out_ready       = 1'b0;
    in_steady       = 1'b0;
    phase_homes = '{10'd1023, 10'd0, 10'($urandom_range(0, 1023)), 10'd1, 10'd1022,
                    10'($urandom_range(0, 1023)), 10'd440, 10'($urandom_range(0, 1023))};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    knob_words.push_back(3'd4);
    knob_words.push_back(3'd5);
    knob_words.push_back(3'd6);
    add_detent(1'b1, 4);
    knob_words.push_back({1'b0, PH_B});
    add_detent(1'b0, 4);
    add_detent(1'b1, 1);
    knob_words.push_back({1'b0, PH_REST});
    knob_words.push_back({1'b0, PH_B});
    play_knob_words();

    write_home(10'd1023);
    knob_words.push_back(PUSH_WORD);
    add_detent(1'b1, 4);
    play_knob_words();

    write_home(10'd0);
    knob_words.push_back(PUSH_WORD);
    add_detent(1'b0, 4);
    play_knob_words();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_home(phase_homes[p]);
      in_steady = ($urandom_range(0, 3) == 0);
      cw_bias   = $urandom_range(0, 10);
      while (knob_words.size() < PHASE_ITEMS) begin
        pick = $urandom_range(0, 15);
        if (pick < 10) begin
          add_detent($urandom_range(0, 9) < cw_bias, 4);
        end else if (pick < 11) begin
          knob_words.push_back(PUSH_WORD);
        end else if (pick < 13) begin
          add_detent(1'($urandom_range(0, 1)), $urandom_range(1, 3));
        end else if (pick < 15) begin
          knob_words.push_back(word_t'($urandom_range(0, 7)));
        end else begin
          knob_words.push_back(word_t'($urandom_range(4, 6)));
        end
      end
      play_knob_words();
    end

    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
